// ===== rtl/mbrc_pkg.sv =====
package mbrc_pkg;

  localparam int RX_W     = 8;
  localparam int WORD_W   = 16;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int CRC_W    = 16;

  // Cap on buffered words, set by the width of the reg_index field.
  localparam int WORD_CAP = 8;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [RX_W-1:0]  FUNC_READ_HOLDING = 8'h03;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  // Input item kinds.
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_BOUNDARY = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_FRAME_LEN  = 1'b1;

  localparam logic [RX_W-1:0]  SLAVE_ADDR_RST = 8'h01;
  localparam logic [LEN_W-1:0] FRAME_LEN_RST  = 5'd7;
  localparam logic [LEN_W-1:0] FRAME_LEN_MIN  = 5'd7;

  // Byte positions inside a response.
  localparam logic [LEN_W-1:0] POS_ADDR  = 5'd0;
  localparam logic [LEN_W-1:0] POS_FUNC  = 5'd1;
  localparam logic [LEN_W-1:0] POS_DATA  = 5'd3;
  localparam logic [LEN_W-1:0] LEN_FIXED = 5'd5;

  typedef struct packed {
    logic [WORD_W-1:0]   reg_word;
    logic [INDEX_W-1:0]  reg_index;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  typedef struct packed {
    logic            init;
    logic            start;
    logic [RX_W-1:0] data;
  } crc_cmd_t;

endpackage

// ===== rtl/mbrc_in_if.sv =====
interface mbrc_in_if import mbrc_pkg::*;;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [RX_W-1:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

// ===== rtl/mbrc_out_if.sv =====
interface mbrc_out_if import mbrc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   reg_word;
  logic [INDEX_W-1:0]  reg_index;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, reg_word, reg_index, status, last, input ready);
  modport sink   (input valid, reg_word, reg_index, status, last, output ready);
endinterface

// ===== rtl/mbrc_crc_serial.sv =====
module mbrc_crc_serial import mbrc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  crc_cmd_t         cmd,
  output logic             busy,
  output logic [CRC_W-1:0] crc
);

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [RX_W-1:0]  data_r, data_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             fb;

  // One data bit per cycle, least significant first, reflected polynomial.
  assign fb = crc_r[0] ^ data_r[0];

  always_comb begin
    crc_nxt  = crc_r;
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.init) begin
      crc_nxt = CRC_INIT;
    end else if (cmd.start) begin
      data_nxt = cmd.data;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt  = {1'b0, crc_r[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
      data_nxt = {1'b0, data_r[RX_W-1:1]};
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    data_r <= data_nxt;
  end

  assign busy = busy_r;
  assign crc  = crc_r;

endmodule

// ===== rtl/mbrc_out_reg.sv =====
module mbrc_out_reg import mbrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       space,
  mbrc_out_if.source out_chan
);

  logic valid_r;
  res_t res_r;

  assign space = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.reg_word  = res_r.reg_word;
  assign out_chan.reg_index = res_r.reg_index;
  assign out_chan.status    = res_r.status;
  assign out_chan.last      = res_r.last;

endmodule

// ===== rtl/modbus_response_checker_top.sv =====
// A byte that enters the CRC keeps the bit-serial CRC unit busy, and no new byte is taken until
// the unit is done; silent boundaries and bytes that bypass the CRC, the closing byte apart, do not hold the input.
// The closing byte or a timeout boundary moves the control state to emission, where results
// enter the output register whenever it has space, one word per cycle while the sink is ready;
// input resumes once the final result of the frame is loaded.
// Synchronous active-low reset clears control state, slave address 1, frame length 7.
module modbus_response_checker_top import mbrc_pkg::*; #(
  parameter int MAX_REGS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mbrc_in_if.sink     in_chan,
  mbrc_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Words that can actually be buffered: the parameter, capped by the index field.
  localparam int REG_CAP = (MAX_REGS < WORD_CAP) ? MAX_REGS : WORD_CAP;
  localparam int IDX_W   = (REG_CAP > 1) ? $clog2(REG_CAP) : 1;
  localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(5 + 2 * REG_CAP);

  // Control states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r, state_nxt;

  // Configuration registers.
  logic [RX_W-1:0]  slave_addr_r;
  logic [LEN_W-1:0] frame_len_r;
  logic             cfg_wr;

  // Frame state.
  logic [LEN_W-1:0]   byte_count_r, byte_count_nxt;
  logic               header_ok_r, header_ok_nxt;
  logic [RX_W-1:0]    crc_low_r, crc_low_nxt;
  logic               frame_done_r, frame_done_nxt;
  logic [WORD_W-1:0]  word_store [REG_CAP];

  // Emission bookkeeping: the status to send, the current word and the final word.
  logic [STATUS_W-1:0] em_status_r, em_status_nxt;
  logic [INDEX_W-1:0]  em_k_r, em_k_nxt;
  logic [INDEX_W-1:0]  em_last_k_r, em_last_k_nxt;

  logic             accept;
  logic [LEN_W-1:0] eff_len;
  logic [3:0]       regs;
  logic [LEN_W:0]   pos_next;
  logic [LEN_W:0]   data_end;
  logic [LEN_W-1:0] data_off;
  logic [3:0]       word_sel;
  logic             word_wr;
  logic             crc_busy;
  logic [CRC_W-1:0] crc_val;
  crc_cmd_t         crc_cmd;
  logic             out_space;
  logic             out_load;
  res_t             out_res;
  logic             em_final;

  // ---------------------------------------------------------------------------
  // Configuration port. Every transaction completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
      frame_len_r  <= FRAME_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SLAVE_ADDR: slave_addr_r <= pwdata[RX_W-1:0];
        REG_FRAME_LEN:  frame_len_r  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLAVE_ADDR: prdata = {{(32-RX_W){1'b0}}, slave_addr_r};
      REG_FRAME_LEN:  prdata = {{(32-LEN_W){1'b0}}, frame_len_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame tracking. The length register is clamped to the range the buffer can
  // hold, and the register count is derived from the clamped length.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (frame_len_r < FRAME_LEN_MIN) begin
      eff_len = FRAME_LEN_MIN;
    end else if (frame_len_r > LEN_TOP) begin
      eff_len = LEN_TOP;
    end else begin
      eff_len = frame_len_r;
    end
  end

  assign regs     = 4'((eff_len - LEN_FIXED) >> 1);
  assign pos_next = {1'b0, byte_count_r} + 6'd1;
  assign data_end = {1'b0, POS_DATA} + {1'b0, regs, 1'b0};
  assign data_off = byte_count_r - POS_DATA;
  assign word_sel = data_off[LEN_W-1:1];

  // A new transaction is taken only while no emission is pending and the CRC
  // unit has finished the previous byte. A waiting result does not block it.
  assign in_chan.ready = (state_r == S_IDLE) && !crc_busy;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    header_ok_nxt  = header_ok_r;
    crc_low_nxt    = crc_low_r;
    frame_done_nxt = frame_done_r;
    em_status_nxt  = em_status_r;
    em_k_nxt       = em_k_r;
    em_last_k_nxt  = em_last_k_r;
    crc_cmd        = '{init: 1'b0, start: 1'b0, data: in_chan.rx_byte};
    word_wr        = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.req_type == REQ_BOUNDARY) begin
            // A boundary always restarts the frame; it reports a timeout
            // only when the frame had not yet completed.
            byte_count_nxt = '0;
            header_ok_nxt  = 1'b1;
            crc_low_nxt    = '0;
            frame_done_nxt = 1'b0;
            crc_cmd.init   = 1'b1;
            if (!frame_done_r) begin
              em_status_nxt = ST_TIMEOUT;
              em_k_nxt      = '0;
              state_nxt     = S_EMIT;
            end
          end else if (!frame_done_r) begin
            if (pos_next >= {1'b0, eff_len}) begin
              // Closing byte: the CRC high byte. CRC errors take precedence.
              frame_done_nxt = 1'b1;
              em_k_nxt       = '0;
              em_last_k_nxt  = INDEX_W'(regs - 4'd1);
              if ({in_chan.rx_byte, crc_low_r} != crc_val) begin
                em_status_nxt = ST_BAD_CRC;
              end else if (!header_ok_r) begin
                em_status_nxt = ST_BAD_HDR;
              end else begin
                em_status_nxt = ST_OK;
              end
              state_nxt = S_EMIT;
            end else begin
              byte_count_nxt = byte_count_r + 5'd1;
              if (pos_next + 6'd1 == {1'b0, eff_len}) begin
                crc_low_nxt = in_chan.rx_byte;
              end else begin
                crc_cmd.start = 1'b1;
                if (byte_count_r == POS_ADDR && in_chan.rx_byte != slave_addr_r) begin
                  header_ok_nxt = 1'b0;
                end
                if (byte_count_r == POS_FUNC && in_chan.rx_byte != FUNC_READ_HOLDING) begin
                  header_ok_nxt = 1'b0;
                end
                if (byte_count_r >= POS_DATA && {1'b0, byte_count_r} < data_end) begin
                  word_wr = 1'b1;
                end
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (out_space) begin
          out_load = 1'b1;
          if (em_final) begin
            state_nxt = S_IDLE;
          end else begin
            em_k_nxt = em_k_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      byte_count_r <= '0;
      header_ok_r  <= 1'b1;
      crc_low_r    <= '0;
      frame_done_r <= 1'b0;
      em_status_r  <= ST_OK;
      em_k_r       <= '0;
      em_last_k_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      header_ok_r  <= header_ok_nxt;
      crc_low_r    <= crc_low_nxt;
      frame_done_r <= frame_done_nxt;
      em_status_r  <= em_status_nxt;
      em_k_r       <= em_k_nxt;
      em_last_k_r  <= em_last_k_nxt;
    end
  end

  // Word buffer: the high byte arrives first and clears the low half; the
  // following byte fills the low half.
  always_ff @(posedge clk) begin
    if (word_wr) begin
      if (!data_off[0]) begin
        word_store[word_sel[IDX_W-1:0]] <= {in_chan.rx_byte, {RX_W{1'b0}}};
      end else begin
        word_store[word_sel[IDX_W-1:0]][RX_W-1:0] <= in_chan.rx_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result formation. Status results carry zero word and index.
  // ---------------------------------------------------------------------------
  assign em_final = (em_status_r != ST_OK) || (em_k_r == em_last_k_r);

  always_comb begin
    out_res.status = em_status_r;
    out_res.last   = em_final;
    if (em_status_r == ST_OK) begin
      out_res.reg_word  = word_store[em_k_r[IDX_W-1:0]];
      out_res.reg_index = em_k_r;
    end else begin
      out_res.reg_word  = '0;
      out_res.reg_index = '0;
    end
  end

  mbrc_crc_serial u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  mbrc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .res      (out_res),
    .space    (out_space),
    .out_chan (out_chan)
  );

endmodule
